// ===== design/pfde_pkg.sv =====
// Package for the page frame store drawing engine.
// Holds the opcode and state types, store geometry and the buses between modules.
// Depends on nothing.
package pfde_pkg;

  localparam int StoreDepth = 1024;
  localparam int AddrW      = 10;
  localparam int CoordW     = 11;
  localparam int DataW      = 8;

  typedef enum logic [2:0] {
    OP_PIXEL      = 3'd0,
    OP_HLINE      = 3'd1,
    OP_VLINE      = 3'd2,
    OP_RECT       = 3'd3,
    OP_FILL_RECT  = 3'd4,
    OP_FILL_STORE = 3'd5,
    OP_READ       = 3'd6,
    OP_NONE       = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_BOX,
    ST_RD,
    ST_WR,
    ST_RDB,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] data;
  } result_t;

endpackage

// ===== design/pfde_store.sv =====
// Frame store: 1024 bytes, one write port and one registered read port.
// Depends on pfde_pkg for the request bus.
module pfde_store (
  input  logic                                clk,
  input  pfde_pkg::mem_req_t                  req,
  output logic [pfde_pkg::DataW-1:0]          rdata
);

  logic [pfde_pkg::DataW-1:0] mem [pfde_pkg::StoreDepth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== design/pfde_ctrl.sv =====
// Command sequencer: orders and clips each box, then walks it one pixel at a
// time with a read-modify-write of the store byte. Also runs the store sweeps.
// Depends on pfde_pkg.
module pfde_ctrl #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           opcode,
  input  logic signed [pfde_pkg::CoordW-1:0]   x1,
  input  logic signed [pfde_pkg::CoordW-1:0]   y1,
  input  logic signed [pfde_pkg::CoordW-1:0]   x2,
  input  logic signed [pfde_pkg::CoordW-1:0]   y2,
  input  logic                                 pixel_state,
  input  logic                                 expand,
  input  logic [pfde_pkg::DataW-1:0]           fill_value,
  input  logic [pfde_pkg::AddrW-1:0]           read_index,
  output pfde_pkg::mem_req_t                   mem_req,
  input  logic [pfde_pkg::DataW-1:0]           rdata,
  output pfde_pkg::result_t                    res
);

  localparam int XW     = $clog2(SCREEN_WIDTH);
  localparam int YW     = $clog2(SCREEN_HEIGHT);
  localparam int IdxMax = ((SCREEN_HEIGHT - 1) / 8) * SCREEN_WIDTH + SCREEN_WIDTH - 1;
  localparam int IW     = $clog2(IdxMax + 1) + 1;
  localparam int CW     = pfde_pkg::CoordW;

  localparam logic signed [CW-1:0] XMax = CW'(SCREEN_WIDTH - 1);
  localparam logic signed [CW-1:0] YMax = CW'(SCREEN_HEIGHT - 1);
  localparam logic signed [CW-1:0] Zero = '0;

  pfde_pkg::state_t state, state_next;
  pfde_pkg::op_t    op;

  logic signed [CW-1:0]         rx1, rx2, ry1, ry2;
  logic                         on;
  logic [pfde_pkg::AddrW-1:0]   ridx;
  logic [pfde_pkg::DataW-1:0]   fillv;
  logic                         sweep_res;
  logic [pfde_pkg::AddrW-1:0]   cnt;
  logic [1:0]                   box;
  logic [XW-1:0]                xa, xb, x;
  logic [YW-1:0]                ya, yb, y;

  // Ordering and growth of the incoming command.
  pfde_pkg::op_t        in_op;
  logic                 ordx, ordy, grow;
  logic signed [CW-1:0] ox1, ox2, oy1, oy2, ey1, ey2;

  always_comb begin
    in_op = pfde_pkg::op_t'(opcode);
    ordx  = (in_op == pfde_pkg::OP_HLINE) || (in_op == pfde_pkg::OP_RECT) ||
            (in_op == pfde_pkg::OP_FILL_RECT);
    ordy  = (in_op == pfde_pkg::OP_VLINE) || (in_op == pfde_pkg::OP_RECT) ||
            (in_op == pfde_pkg::OP_FILL_RECT);
    grow  = (in_op == pfde_pkg::OP_FILL_RECT) && expand;
    ox1   = (ordx && (x1 > x2)) ? x2 : x1;
    ox2   = (ordx && (x1 > x2)) ? x1 : x2;
    oy1   = (ordy && (y1 > y2)) ? y2 : y1;
    oy2   = (ordy && (y1 > y2)) ? y1 : y2;
    ey1   = (grow && (oy1 > Zero)) ? oy1 - CW'(1) : oy1;
    ey2   = (grow && (oy2 < YMax)) ? oy2 + CW'(1) : oy2;
  end

  // Box selection for the current step of the command.
  logic signed [CW-1:0] bx1, bx2, by1, by2, cxa, cxb, cya, cyb;
  logic [1:0]           box_last;
  logic                 empty, last_box;

  always_comb begin
    bx1 = rx1;
    bx2 = rx2;
    by1 = ry1;
    by2 = ry2;
    unique case (op)
      pfde_pkg::OP_PIXEL: begin
        bx2 = rx1;
        by2 = ry1;
      end
      pfde_pkg::OP_HLINE: by2 = ry1;
      pfde_pkg::OP_VLINE: bx2 = rx1;
      pfde_pkg::OP_RECT: begin
        unique case (box)
          2'd0:    bx2 = rx1;
          2'd1:    bx1 = rx2;
          2'd2:    by2 = ry1;
          default: by1 = ry2;
        endcase
      end
      default: ;
    endcase
    box_last = (op == pfde_pkg::OP_RECT) ? 2'd3 : 2'd0;
    last_box = (box == box_last);
    cxa   = (bx1 < Zero) ? Zero : bx1;
    cxb   = (bx2 > XMax) ? XMax : bx2;
    cya   = (by1 < Zero) ? Zero : by1;
    cyb   = (by2 > YMax) ? YMax : by2;
    empty = (cxa > cxb) || (cya > cyb);
  end

  // Byte index of the current pixel; pages are eight rows tall.
  logic [IW-1:0]              idx;
  logic                       oor, x_end, y_end, advance;
  logic [pfde_pkg::DataW-1:0] mask;

  assign idx   = ((IW'(y) >> 3) * IW'(SCREEN_WIDTH)) + IW'(x);
  assign oor   = (int'(idx) >= pfde_pkg::StoreDepth);
  assign x_end = (x == xb);
  assign y_end = (y == yb);
  assign mask  = pfde_pkg::DataW'(1) << y[2:0];
  assign advance = (state == pfde_pkg::ST_WR) || ((state == pfde_pkg::ST_RD) && oor);

  always_comb begin
    state_next    = state;
    mem_req.we    = 1'b0;
    mem_req.waddr = pfde_pkg::AddrW'(idx);
    mem_req.wdata = on ? (rdata | mask) : (rdata & ~mask);
    mem_req.raddr = pfde_pkg::AddrW'(idx);
    res.valid     = 1'b0;
    res.data      = (op == pfde_pkg::OP_READ) ? rdata : '0;
    unique case (state)
      pfde_pkg::ST_SWEEP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt;
        mem_req.wdata = fillv;
        if (cnt == '1) begin
          state_next = sweep_res ? pfde_pkg::ST_FIN : pfde_pkg::ST_IDLE;
        end
      end
      pfde_pkg::ST_IDLE: begin
        if (start) begin
          unique case (in_op)
            pfde_pkg::OP_FILL_STORE: state_next = pfde_pkg::ST_SWEEP;
            pfde_pkg::OP_READ:       state_next = pfde_pkg::ST_RDB;
            pfde_pkg::OP_NONE:       state_next = pfde_pkg::ST_FIN;
            default:                 state_next = pfde_pkg::ST_BOX;
          endcase
        end
      end
      pfde_pkg::ST_BOX: begin
        if (!empty) begin
          state_next = pfde_pkg::ST_RD;
        end else if (last_box) begin
          state_next = pfde_pkg::ST_FIN;
        end
      end
      pfde_pkg::ST_RD, pfde_pkg::ST_WR: begin
        if (state == pfde_pkg::ST_WR) begin
          mem_req.we = 1'b1;
        end
        if (state == pfde_pkg::ST_RD && !oor) begin
          state_next = pfde_pkg::ST_WR;
        end else if (!(x_end && y_end)) begin
          state_next = pfde_pkg::ST_RD;
        end else begin
          state_next = last_box ? pfde_pkg::ST_FIN : pfde_pkg::ST_BOX;
        end
      end
      pfde_pkg::ST_RDB: begin
        mem_req.raddr = ridx;
        state_next    = pfde_pkg::ST_FIN;
      end
      pfde_pkg::ST_FIN: begin
        res.valid  = 1'b1;
        state_next = pfde_pkg::ST_IDLE;
      end
      default: state_next = pfde_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state != pfde_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfde_pkg::ST_SWEEP;
      cnt       <= '0;
      fillv     <= '0;
      sweep_res <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pfde_pkg::ST_SWEEP) begin
        cnt <= cnt + pfde_pkg::AddrW'(1);
      end
      if (state == pfde_pkg::ST_IDLE && start) begin
        op        <= in_op;
        rx1       <= ox1;
        rx2       <= ox2;
        ry1       <= ey1;
        ry2       <= ey2;
        on        <= (in_op == pfde_pkg::OP_PIXEL || in_op == pfde_pkg::OP_HLINE ||
                      in_op == pfde_pkg::OP_VLINE) ? pixel_state : 1'b1;
        ridx      <= read_index;
        fillv     <= fill_value;
        sweep_res <= 1'b1;
        cnt       <= '0;
        box       <= '0;
      end
      if (state == pfde_pkg::ST_BOX) begin
        if (!empty) begin
          xa <= XW'(cxa);
          xb <= XW'(cxb);
          x  <= XW'(cxa);
          ya <= YW'(cya);
          yb <= YW'(cyb);
          y  <= YW'(cya);
        end else if (!last_box) begin
          box <= box + 2'd1;
        end
      end
      if (advance) begin
        if (!x_end) begin
          x <= x + XW'(1);
        end else begin
          x <= xa;
          if (!y_end) begin
            y <= y + YW'(1);
          end else if (!last_box) begin
            box <= box + 2'd1;
          end
        end
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the engine busy");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == pfde_pkg::ST_IDLE) |-> !mem_req.we)
    else $error("store written while idle");

  a_walk_in_box: assert property (@(posedge clk) disable iff (rst)
    (state == pfde_pkg::ST_WR) |-> (x >= xa && x <= xb && y >= ya && y <= yb))
    else $error("pixel walk left its box");

  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    (res.valid && op != pfde_pkg::OP_READ) |-> (res.data == '0))
    else $error("non-read command returned data");

  a_write_follows_read: assert property (@(posedge clk) disable iff (rst)
    (state == pfde_pkg::ST_WR) |-> ($past(state) == pfde_pkg::ST_RD && !$past(oor)))
    else $error("store write without a preceding read");

endmodule

// ===== design/page_framebuffer_draw_engine.sv =====
// Drawing engine over a monochrome page-organised frame store. Commands are
// taken when start is high and busy is low; each yields one item on read_data,
// marked by done for one cycle, which cannot be held off. Work is sequential:
// a pixel, line or rectangle fill is walked one on-screen pixel at a time with
// a read and then a write of its store byte (a pixel beyond the store is read
// but not written), a rectangle outline walks its four sides in turn, a store
// fill writes every store byte and a read fetches one byte. After reset the
// store is cleared in a sweep pass during which busy stays high.
// Depends on pfde_pkg, pfde_store and pfde_ctrl.
module page_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           opcode,
  input  logic signed [pfde_pkg::CoordW-1:0]   x1,
  input  logic signed [pfde_pkg::CoordW-1:0]   y1,
  input  logic signed [pfde_pkg::CoordW-1:0]   x2,
  input  logic signed [pfde_pkg::CoordW-1:0]   y2,
  input  logic                                 pixel_state,
  input  logic                                 expand,
  input  logic [pfde_pkg::DataW-1:0]           fill_value,
  input  logic [pfde_pkg::AddrW-1:0]           read_index,
  output logic                                 done,
  output logic [pfde_pkg::DataW-1:0]           read_data
);

  pfde_pkg::mem_req_t         mem_req;
  pfde_pkg::result_t          res;
  logic [pfde_pkg::DataW-1:0] rdata;

  pfde_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  pfde_ctrl #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .x1          (x1),
    .y1          (y1),
    .x2          (x2),
    .y2          (y2),
    .pixel_state (pixel_state),
    .expand      (expand),
    .fill_value  (fill_value),
    .read_index  (read_index),
    .mem_req     (mem_req),
    .rdata       (rdata),
    .res         (res)
  );

  // Result register: the item is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
    read_data <= res.data;
  end

endmodule
